>>> hw/rtl/gssc_pkg.sv
// gssc_pkg: shared types and constants of the gimbal setpoint speed controller
// holds the register map, reset values, command struct and fixed output values
// depends on nothing
package gssc_pkg;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_YAW_STEP        = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PITCH_STEP      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PITCH_UPPER     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PITCH_LOWER     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ANGLE_GAIN      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_YAW_SPEED_MAX   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_PITCH_SPEED_MAX = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_ROTOR_SCALE     = 3'd7;

	localparam logic [14:0] RST_YAW_STEP        = 15'd1043;
	localparam logic [14:0] RST_PITCH_STEP      = 15'd313;
	localparam logic [15:0] RST_PITCH_UPPER     = 16'd2608;
	localparam logic [15:0] RST_PITCH_LOWER     = 16'hEFB4;
	localparam logic [15:0] RST_ANGLE_GAIN      = 16'd12566;
	localparam logic [14:0] RST_YAW_SPEED_MAX   = 15'd500;
	localparam logic [14:0] RST_PITCH_SPEED_MAX = 15'd300;
	localparam logic [14:0] RST_ROTOR_SCALE     = 15'd10000;

	typedef struct packed {
		logic [14:0] yaw_step;
		logic [14:0] pitch_step;
		logic [15:0] pitch_upper;
		logic [15:0] pitch_lower;
		logic [15:0] angle_gain;
		logic [14:0] yaw_speed_max;
		logic [14:0] pitch_speed_max;
		logic [14:0] rotor_scale;
	} cfg_t;

	// multiplier operand selection
	localparam int MUL_SEL_W = 3;
	localparam logic [MUL_SEL_W-1:0] MUL_YAW_AXIS   = 3'd0;
	localparam logic [MUL_SEL_W-1:0] MUL_PITCH_AXIS = 3'd1;
	localparam logic [MUL_SEL_W-1:0] MUL_YAW_ERR    = 3'd2;
	localparam logic [MUL_SEL_W-1:0] MUL_PITCH_ERR  = 3'd3;
	localparam logic [MUL_SEL_W-1:0] MUL_ROTOR_AXIS = 3'd4;

	typedef struct packed {
		logic                 load_in;
		logic                 load_held;
		logic                 mul_en;
		logic [MUL_SEL_W-1:0] mul_sel;
		logic                 upd_yaw;
		logic                 upd_pitch;
		logic                 set_yaw_speed;
		logic                 set_pitch_speed;
		logic                 set_out;
	} cmd_t;

	localparam logic [8:0]  GIMBAL_GAIN        = 9'd300;
	localparam logic [3:0]  ROTOR_GAIN         = 4'd10;
	localparam logic [4:0]  FEEDER_GAIN        = 5'd20;
	localparam logic [13:0] LEFT_FEEDER_SPEED  = 14'h2C78;
	localparam logic [12:0] RIGHT_FEEDER_SPEED = 13'd5000;

endpackage

>>> hw/rtl/gssc_cfg_regs.sv
// gssc_cfg_regs: configuration register file of the controller
// write-only registers loaded from the plain write port
// depends on gssc_pkg
module gssc_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [gssc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [gssc_pkg::CFG_DATA_W-1:0]  cfg_data,
	output gssc_pkg::cfg_t                   cfg
);

	gssc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.yaw_step        <= gssc_pkg::RST_YAW_STEP;
			cfg_q.pitch_step      <= gssc_pkg::RST_PITCH_STEP;
			cfg_q.pitch_upper     <= gssc_pkg::RST_PITCH_UPPER;
			cfg_q.pitch_lower     <= gssc_pkg::RST_PITCH_LOWER;
			cfg_q.angle_gain      <= gssc_pkg::RST_ANGLE_GAIN;
			cfg_q.yaw_speed_max   <= gssc_pkg::RST_YAW_SPEED_MAX;
			cfg_q.pitch_speed_max <= gssc_pkg::RST_PITCH_SPEED_MAX;
			cfg_q.rotor_scale     <= gssc_pkg::RST_ROTOR_SCALE;
		end else if (cfg_we) begin
			case (cfg_index)
				gssc_pkg::REG_YAW_STEP:        cfg_q.yaw_step        <= cfg_data[14:0];
				gssc_pkg::REG_PITCH_STEP:      cfg_q.pitch_step      <= cfg_data[14:0];
				gssc_pkg::REG_PITCH_UPPER:     cfg_q.pitch_upper     <= cfg_data;
				gssc_pkg::REG_PITCH_LOWER:     cfg_q.pitch_lower     <= cfg_data;
				gssc_pkg::REG_ANGLE_GAIN:      cfg_q.angle_gain      <= cfg_data;
				gssc_pkg::REG_YAW_SPEED_MAX:   cfg_q.yaw_speed_max   <= cfg_data[14:0];
				gssc_pkg::REG_PITCH_SPEED_MAX: cfg_q.pitch_speed_max <= cfg_data[14:0];
				gssc_pkg::REG_ROTOR_SCALE:     cfg_q.rotor_scale     <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> hw/rtl/gssc_ctrl.sv
// gssc_ctrl: sequencing state machine of the controller
// steps the shared multiplier through five products and owns both handshakes
// depends on gssc_pkg
module gssc_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic           kind,
	output logic           out_valid,
	input  logic           out_ready,
	output gssc_pkg::cmd_t cmd
);

	localparam logic [2:0] ST_IDLE      = 3'd0;
	localparam logic [2:0] ST_YAW_AXIS  = 3'd1;
	localparam logic [2:0] ST_PITCH_AX  = 3'd2;
	localparam logic [2:0] ST_YAW_ERR   = 3'd3;
	localparam logic [2:0] ST_PITCH_ERR = 3'd4;
	localparam logic [2:0] ST_ROTOR     = 3'd5;
	localparam logic [2:0] ST_OUT       = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic       accept;
	logic       out_free;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.mul_sel = gssc_pkg::MUL_YAW_AXIS;
		case (state_q)
			ST_IDLE: begin
				cmd.load_in   = accept && kind;
				cmd.load_held = accept && !kind;
				if (accept && kind) begin
					state_d = ST_YAW_AXIS;
				end
			end
			ST_YAW_AXIS: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = gssc_pkg::MUL_YAW_AXIS;
				state_d     = ST_PITCH_AX;
			end
			ST_PITCH_AX: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = gssc_pkg::MUL_PITCH_AXIS;
				cmd.upd_yaw = 1'b1;
				state_d     = ST_YAW_ERR;
			end
			ST_YAW_ERR: begin
				cmd.mul_en    = 1'b1;
				cmd.mul_sel   = gssc_pkg::MUL_YAW_ERR;
				cmd.upd_pitch = 1'b1;
				state_d       = ST_PITCH_ERR;
			end
			ST_PITCH_ERR: begin
				cmd.mul_en        = 1'b1;
				cmd.mul_sel       = gssc_pkg::MUL_PITCH_ERR;
				cmd.set_yaw_speed = 1'b1;
				state_d           = ST_ROTOR;
			end
			ST_ROTOR: begin
				cmd.mul_en          = 1'b1;
				cmd.mul_sel         = gssc_pkg::MUL_ROTOR_AXIS;
				cmd.set_pitch_speed = 1'b1;
				state_d             = ST_OUT;
			end
			ST_OUT: begin
				cmd.set_out = out_free;
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.set_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

>>> hw/rtl/gssc_datapath.sv
// gssc_datapath: targets, latched angles, shared multiplier and result registers
// driven by the command struct of gssc_ctrl
// depends on gssc_pkg
module gssc_datapath #(
	parameter int ANGLE_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  gssc_pkg::cmd_t     cmd,
	input  gssc_pkg::cfg_t     cfg,
	input  logic signed [15:0] measured_yaw,
	input  logic signed [15:0] measured_pitch,
	input  logic signed [15:0] axis_yaw,
	input  logic signed [15:0] axis_pitch,
	input  logic signed [15:0] axis_rotor,
	input  logic               aim_button,
	input  logic               fire_button,
	output logic               gimbal_enable,
	output logic [8:0]         gimbal_gain,
	output logic signed [15:0] yaw_speed,
	output logic signed [15:0] pitch_speed,
	output logic               shooter_enable,
	output logic [3:0]         rotor_gain,
	output logic [4:0]         feeder_gain,
	output logic signed [15:0] rotor_speed,
	output logic signed [13:0] left_feeder_speed,
	output logic [12:0]        right_feeder_speed
);

	localparam int OPA_W = (ANGLE_BITS > 17) ? ANGLE_BITS : 17;
	localparam int PW    = OPA_W + 17;

	logic signed [ANGLE_BITS-1:0] yaw_target_q;
	logic signed [15:0]           pitch_target_q;
	logic signed [15:0]           held_yaw_q;
	logic signed [15:0]           held_pitch_q;
	logic signed [15:0]           axis_yaw_q;
	logic signed [15:0]           axis_pitch_q;
	logic signed [15:0]           axis_rotor_q;
	logic                         aim_q;
	logic                         fire_q;
	logic signed [PW-1:0]         prod_q;
	logic signed [15:0]           yaw_speed_q;
	logic signed [15:0]           pitch_speed_q;

	logic                         gimbal_on;
	logic signed [ANGLE_BITS-1:0] err_yaw;
	logic signed [ANGLE_BITS-1:0] err_pitch;
	logic signed [OPA_W-1:0]      op_a;
	logic signed [16:0]           op_b;
	logic signed [PW-1:0]         bias15;
	logic signed [PW-1:0]         bias16;
	logic signed [PW-1:0]         q15;
	logic signed [PW-1:0]         q16;
	logic signed [OPA_W-1:0]      delta;
	logic signed [17:0]           pitch_sum;
	logic signed [17:0]           upper_x;
	logic signed [17:0]           lower_x;
	logic signed [15:0]           pitch_next;
	logic signed [PW-1:0]         smax;
	logic signed [15:0]           speed_sat;

	assign gimbal_on = aim_q || fire_q;

	assign err_yaw   = yaw_target_q - ANGLE_BITS'(held_yaw_q);
	assign err_pitch = ANGLE_BITS'(pitch_target_q) - ANGLE_BITS'(held_pitch_q);

	always_comb begin
		case (cmd.mul_sel)
			gssc_pkg::MUL_YAW_AXIS: begin
				op_a = -OPA_W'(axis_yaw_q);
				op_b = $signed({2'b00, cfg.yaw_step});
			end
			gssc_pkg::MUL_PITCH_AXIS: begin
				op_a = -OPA_W'(axis_pitch_q);
				op_b = $signed({2'b00, cfg.pitch_step});
			end
			gssc_pkg::MUL_YAW_ERR: begin
				op_a = OPA_W'(err_yaw);
				op_b = $signed({1'b0, cfg.angle_gain});
			end
			gssc_pkg::MUL_PITCH_ERR: begin
				op_a = OPA_W'(err_pitch);
				op_b = $signed({1'b0, cfg.angle_gain});
			end
			gssc_pkg::MUL_ROTOR_AXIS: begin
				op_a = -OPA_W'(axis_rotor_q);
				op_b = $signed({2'b00, cfg.rotor_scale});
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	// quotients truncated toward zero
	assign bias15 = prod_q[PW-1] ? PW'(32'sd32767) : '0;
	assign bias16 = prod_q[PW-1] ? PW'(32'sd65535) : '0;
	assign q15    = (prod_q + bias15) >>> 15;
	assign q16    = (prod_q + bias16) >>> 16;
	assign delta  = q15[OPA_W-1:0];

	assign pitch_sum = 18'(pitch_target_q) + 18'(delta);
	assign upper_x   = 18'($signed(cfg.pitch_upper));
	assign lower_x   = 18'($signed(cfg.pitch_lower));

	always_comb begin
		if (pitch_sum > upper_x) begin
			pitch_next = cfg.pitch_upper;
		end else if (pitch_sum < lower_x) begin
			pitch_next = cfg.pitch_lower;
		end else begin
			pitch_next = pitch_sum[15:0];
		end
	end

	always_comb begin
		if (cmd.set_yaw_speed) begin
			smax = PW'($signed({1'b0, cfg.yaw_speed_max}));
		end else begin
			smax = PW'($signed({1'b0, cfg.pitch_speed_max}));
		end
		if (q16 > smax) begin
			speed_sat = smax[15:0];
		end else if (q16 < -smax) begin
			speed_sat = 16'(-smax);
		end else begin
			speed_sat = q16[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			yaw_target_q   <= '0;
			pitch_target_q <= '0;
			held_yaw_q     <= '0;
			held_pitch_q   <= '0;
		end else begin
			if (cmd.load_held) begin
				held_yaw_q   <= measured_yaw;
				held_pitch_q <= measured_pitch;
			end
			if (cmd.upd_yaw && gimbal_on) begin
				yaw_target_q <= yaw_target_q + delta[ANGLE_BITS-1:0];
			end
			if (cmd.upd_pitch && gimbal_on) begin
				pitch_target_q <= pitch_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			axis_yaw_q   <= axis_yaw;
			axis_pitch_q <= axis_pitch;
			axis_rotor_q <= axis_rotor;
			aim_q        <= aim_button;
			fire_q       <= fire_button;
		end
		if (cmd.mul_en) begin
			prod_q <= PW'(op_a) * PW'(op_b);
		end
		if (cmd.set_yaw_speed) begin
			yaw_speed_q <= speed_sat;
		end
		if (cmd.set_pitch_speed) begin
			pitch_speed_q <= speed_sat;
		end
		if (cmd.set_out) begin
			gimbal_enable      <= gimbal_on;
			gimbal_gain        <= gimbal_on ? gssc_pkg::GIMBAL_GAIN : '0;
			yaw_speed          <= gimbal_on ? yaw_speed_q : '0;
			pitch_speed        <= gimbal_on ? pitch_speed_q : '0;
			shooter_enable     <= fire_q;
			rotor_gain         <= fire_q ? gssc_pkg::ROTOR_GAIN : '0;
			feeder_gain        <= fire_q ? gssc_pkg::FEEDER_GAIN : '0;
			rotor_speed        <= fire_q ? q15[15:0] : '0;
			left_feeder_speed  <= fire_q ? gssc_pkg::LEFT_FEEDER_SPEED : '0;
			right_feeder_speed <= fire_q ? gssc_pkg::RIGHT_FEEDER_SPEED : '0;
		end
	end

endmodule

>>> hw/rtl/gimbal_setpoint_speed_controller.sv
// gimbal_setpoint_speed_controller: top level of the gimbal setpoint speed controller
// a joystick item steps the one shared multiplier through five products in turn,
// then registers its result once the output is free; a new item is taken only in idle,
// after the last is through; an attitude item is taken in idle and gives no result
// the result register frees the input side while a result waits for its transfer
// reset: asynchronous, clears targets, held angles and control, loads register defaults
module gimbal_setpoint_speed_controller #(
	parameter int ANGLE_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [gssc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [gssc_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             kind,
	input  logic signed [15:0]               measured_yaw,
	input  logic signed [15:0]               measured_pitch,
	input  logic signed [15:0]               axis_yaw,
	input  logic signed [15:0]               axis_pitch,
	input  logic signed [15:0]               axis_rotor,
	input  logic                             aim_button,
	input  logic                             fire_button,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             gimbal_enable,
	output logic [8:0]                       gimbal_gain,
	output logic signed [15:0]               yaw_speed,
	output logic signed [15:0]               pitch_speed,
	output logic                             shooter_enable,
	output logic [3:0]                       rotor_gain,
	output logic [4:0]                       feeder_gain,
	output logic signed [15:0]               rotor_speed,
	output logic signed [13:0]               left_feeder_speed,
	output logic [12:0]                      right_feeder_speed
);

	gssc_pkg::cfg_t cfg;
	gssc_pkg::cmd_t cmd;

	gssc_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	gssc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.kind      (kind),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	gssc_datapath #(
		.ANGLE_BITS (ANGLE_BITS)
	) u_datapath (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.cfg                (cfg),
		.measured_yaw       (measured_yaw),
		.measured_pitch     (measured_pitch),
		.axis_yaw           (axis_yaw),
		.axis_pitch         (axis_pitch),
		.axis_rotor         (axis_rotor),
		.aim_button         (aim_button),
		.fire_button        (fire_button),
		.gimbal_enable      (gimbal_enable),
		.gimbal_gain        (gimbal_gain),
		.yaw_speed          (yaw_speed),
		.pitch_speed        (pitch_speed),
		.shooter_enable     (shooter_enable),
		.rotor_gain         (rotor_gain),
		.feeder_gain        (feeder_gain),
		.rotor_speed        (rotor_speed),
		.left_feeder_speed  (left_feeder_speed),
		.right_feeder_speed (right_feeder_speed)
	);

endmodule
